FILE: sv/max_on_time_job_scheduler_core_assert.svh
// Assertion macros for the job scheduler core.
`ifndef MAX_ON_TIME_JOB_SCHEDULER_CORE_ASSERT_SVH
`define MAX_ON_TIME_JOB_SCHEDULER_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define MOTJ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define MOTJ_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MOTJ_ASSERT(lbl, prop, msg)
`define MOTJ_ASSERT_RST(lbl, prop, msg)
`endif
`endif

FILE: sv/motjs_pkg.sv
// Package: shared types and constants of the job scheduler.
package motjs_pkg;
  localparam int DUR_W = 20;
  localparam int DL_W  = 20;
  localparam int CNT_W = 11;

  typedef enum logic [8:0] {
    ST_LOAD   = 9'b000000001,
    ST_SRD    = 9'b000000010,
    ST_SMRG   = 9'b000000100,
    ST_SCOPY  = 9'b000001000,
    ST_WRD    = 9'b000010000,
    ST_WEVAL  = 9'b000100000,
    ST_UP     = 9'b001000000,
    ST_DOWN   = 9'b010000000,
    ST_OUT    = 9'b100000000
  } state_t;
endpackage

FILE: sv/motjs_if.sv
// Valid/ready channel interfaces for job requests and results.
interface motjs_job_if;
  logic                      valid;
  logic                      ready;
  logic [motjs_pkg::DUR_W-1:0] job_duration;
  logic [motjs_pkg::DL_W-1:0]  job_deadline;
  logic                      last_job;
  modport source (output valid, job_duration, job_deadline, last_job, input ready);
  modport sink   (input valid, job_duration, job_deadline, last_job, output ready);
endinterface

interface motjs_res_if;
  logic                        valid;
  logic                        ready;
  logic [motjs_pkg::CNT_W-1:0] accepted_count;
  logic                        overflow;
  modport source (output valid, accepted_count, overflow, input ready);
  modport sink   (input valid, accepted_count, overflow, output ready);
endinterface

FILE: sv/max_on_time_job_scheduler_core.sv
// Top level: Moore-Hodgson maximum on-time job scheduler.
//
// Usage: job requests arrive on the jobs channel (valid/ready); each carries
// a duration, a deadline and last_job. Requests are written to the job
// memory at one per cycle while no earlier result is waiting. A request
// with last_job set closes the batch: the block stops taking requests,
// merge-sorts the stored jobs by deadline (stable; bottom-up passes through
// a scratch memory, each pass followed by a copy-back), then walks them
// keeping a max-heap of chosen durations in a heap memory. The walk reads
// each job, then evaluates it against the running busy time; each heap sift
// step is a memory read followed by a compare/write.
// One result (accepted_count, overflow) leaves on the results channel per
// batch; it sits in an output register until taken, and the next batch is
// accepted only once it has gone. Requests beyond MAX_ORDERS are dropped and
// flag overflow. Reset (rst, synchronous) empties the batch; memory content
// is not cleared, since only written entries are ever read.
module max_on_time_job_scheduler_core #(
  parameter int MAX_ORDERS = 1024
) (
  input logic clk,
  input logic rst,
  motjs_job_if.sink   jobs,
  motjs_res_if.source results
);
  localparam int TIME_BITS = motjs_pkg::DUR_W;
  localparam int AW = (MAX_ORDERS > 1) ? $clog2(MAX_ORDERS) : 1;
  localparam int NW = AW + 1;
  localparam int EW = 2 * TIME_BITS;

  // job store and merge scratch memory
  logic [EW-1:0] store [MAX_ORDERS];
  logic [EW-1:0] scratch [MAX_ORDERS];
  logic [TIME_BITS-1:0] heap [MAX_ORDERS];

  motjs_pkg::state_t state;

  logic [NW-1:0] count;
  logic          dropped;
  logic [NW-1:0] width, lo, mid, hi, a, b, k;
  logic [NW-1:0] i;
  logic [NW-1:0] hsize;
  logic [TIME_BITS:0] busy;
  logic [EW-1:0] ra, rb;
  logic [EW-1:0] cur;
  logic [EW-1:0] sdat;
  logic [TIME_BITS-1:0] top;
  logic [TIME_BITS-1:0] hval;
  logic [NW-1:0] hidx;
  logic [TIME_BITS-1:0] rl, rr, rp;
  logic          res_valid;
  logic [motjs_pkg::CNT_W-1:0] res_count;
  logic          res_ovf;

  assign jobs.ready = (state == motjs_pkg::ST_LOAD) && !res_valid;
  assign results.valid = res_valid;
  assign results.accepted_count = res_count;
  assign results.overflow = res_ovf;

  wire take = jobs.valid && jobs.ready;

  logic [NW:0] mid_sum, hi_sum;
  assign mid_sum = {1'b0, lo} + {1'b0, width};
  assign hi_sum  = {1'b0, mid} + {1'b0, width};

  wire a_live = a < mid;
  wire b_live = b < hi;
  wire pick_b = b_live && (!a_live || (rb[TIME_BITS-1:0] < ra[TIME_BITS-1:0]));

  // child indexes carry one extra bit so the last node never wraps to the root
  wire [NW:0] lc = {hidx, 1'b1};
  wire [NW:0] rc = lc + 1'b1;
  wire [NW-1:0] par = (hidx - 1'b1) >> 1;

  // store port A serves the merge's left run or the walk; port B the right run
  wire [AW-1:0] sa = (state == motjs_pkg::ST_SMRG) ? a[AW-1:0] : i[AW-1:0];
  // heap port A: parent on the way up, left child on the way down, else root
  wire [AW-1:0] ha = (state == motjs_pkg::ST_UP)   ? par[AW-1:0] :
                     (state == motjs_pkg::ST_DOWN) ? lc[AW-1:0]  : '0;

  assign cur = ra;
  assign top = rl;
  assign rp  = rl;

  wire [TIME_BITS-1:0] cdur = cur[EW-1:TIME_BITS];
  wire [TIME_BITS-1:0] cdl  = cur[TIME_BITS-1:0];
  wire [TIME_BITS:0] fit_sum = busy + {1'b0, cdur};

  // Memory reads; registered data for the next cycle.
  always_ff @(posedge clk) begin
    ra <= store[sa];
    rb <= store[b[AW-1:0]];
    sdat <= scratch[k[AW-1:0]];
    rl <= heap[ha];
    rr <= heap[rc[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= motjs_pkg::ST_LOAD;
      count <= '0;
      hsize <= '0;
      dropped <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (results.valid && results.ready) res_valid <= 1'b0;
      unique case (state)
        motjs_pkg::ST_LOAD: begin
          if (take) begin
            if (count < NW'(MAX_ORDERS)) begin
              store[count[AW-1:0]] <= {jobs.job_duration[TIME_BITS-1:0],
                                       jobs.job_deadline[TIME_BITS-1:0]};
              count <= count + 1'b1;
            end else dropped <= 1'b1;
            if (jobs.last_job) begin
              width <= NW'(1);
              lo <= '0;
              state <= motjs_pkg::ST_SRD;
            end
          end
        end
        motjs_pkg::ST_SRD: begin
          // start a run pair, the copy-back of a finished pass, or the walk
          if (width >= count) begin
            i <= '0; hsize <= '0; busy <= '0;
            state <= motjs_pkg::ST_WRD;
          end else if (lo >= count) begin
            k <= '0;
            hidx <= '0; // copy phase
            state <= motjs_pkg::ST_SCOPY;
          end else begin
            mid <= (mid_sum > {1'b0, count}) ? count : mid_sum[NW-1:0];
            a <= lo;
            k <= lo;
            state <= motjs_pkg::ST_SMRG;
            hidx <= '0; // mark first merge cycle
          end
        end
        motjs_pkg::ST_SMRG: begin
          if (hidx == '0) begin
            hi <= (hi_sum > {1'b0, count}) ? count : hi_sum[NW-1:0];
            b <= mid;
            hidx <= NW'(1);
          end else if (hidx == NW'(1)) begin
            hidx <= NW'(2); // read latency
          end else if (hidx == NW'(2)) begin
            if (!a_live && !b_live) begin
              lo <= hi;
              state <= motjs_pkg::ST_SRD;
            end else begin
              scratch[k[AW-1:0]] <= pick_b ? rb : ra;
              k <= k + 1'b1;
              if (pick_b) b <= b + 1'b1; else a <= a + 1'b1;
              hidx <= NW'(1);
            end
          end
        end
        motjs_pkg::ST_SCOPY: begin
          // hidx=0: wait read of scratch; hidx=1: write back
          if (k >= count) begin
            width <= width << 1;
            lo <= '0;
            state <= motjs_pkg::ST_SRD;
          end else if (hidx == '0) begin
            hidx <= NW'(1);
          end else begin
            store[k[AW-1:0]] <= sdat;
            k <= k + 1'b1;
            hidx <= '0;
          end
        end
        motjs_pkg::ST_WRD: begin
          if (i >= count) begin
            res_valid <= 1'b1;
            res_count <= motjs_pkg::CNT_W'(hsize);
            res_ovf <= dropped;
            state <= motjs_pkg::ST_OUT;
          end else state <= motjs_pkg::ST_WEVAL;
        end
        motjs_pkg::ST_WEVAL: begin
          i <= i + 1'b1;
          if (fit_sum <= {1'b0, cdl}) begin
            busy <= fit_sum;
            heap[hsize[AW-1:0]] <= cdur;
            hidx <= hsize;
            hval <= cdur;
            hsize <= hsize + 1'b1;
            state <= (hsize == '0) ? motjs_pkg::ST_WRD : motjs_pkg::ST_UP;
          end else if (hsize != '0 && top > cdur) begin
            busy <= busy - {1'b0, top} + {1'b0, cdur};
            heap[0] <= cdur;
            hidx <= '0;
            hval <= cdur;
            state <= motjs_pkg::ST_DOWN;
          end else state <= motjs_pkg::ST_WRD;
          k <= '0;
        end
        motjs_pkg::ST_UP: begin
          // k=0: wait read of parent; k=1: compare/swap
          if (k == '0) k <= NW'(1);
          else begin
            k <= '0;
            if (rp < hval) begin
              heap[par[AW-1:0]] <= hval;
              heap[hidx[AW-1:0]] <= rp;
              hidx <= par;
              if (par == '0) state <= motjs_pkg::ST_WRD;
            end else state <= motjs_pkg::ST_WRD;
          end
        end
        motjs_pkg::ST_DOWN: begin
          if (k == '0) k <= NW'(1);
          else begin
            k <= '0;
            if (lc < {1'b0, hsize} && rl > hval &&
                !(rc < {1'b0, hsize} && rr > rl)) begin
              heap[lc[AW-1:0]] <= hval;
              heap[hidx[AW-1:0]] <= rl;
              hidx <= lc[NW-1:0];
            end else if (rc < {1'b0, hsize} && rr > hval) begin
              heap[rc[AW-1:0]] <= hval;
              heap[hidx[AW-1:0]] <= rr;
              hidx <= rc[NW-1:0];
            end else state <= motjs_pkg::ST_WRD;
          end
        end
        motjs_pkg::ST_OUT: begin
          count <= '0;
          hsize <= '0;
          dropped <= 1'b0;
          state <= motjs_pkg::ST_LOAD;
        end
        default: state <= motjs_pkg::ST_LOAD;
      endcase
    end
  end

`include "max_on_time_job_scheduler_core_assert.svh"
  `MOTJ_ASSERT(a_onehot, $onehot(state), "state not one-hot")
  `MOTJ_ASSERT(a_cnt, count <= NW'(MAX_ORDERS), "job count past store")
  `MOTJ_ASSERT(a_heap, hsize <= count, "heap larger than batch")
  `MOTJ_ASSERT_RST(a_rst, rst |=> !results.valid, "result after reset")
endmodule

FILE: dv/tb_max_on_time_job_scheduler_core.sv
// Testbench for the max on-time job scheduler: directed and random batches against a predictor.
`timescale 1ns / 100ps

module tb_max_on_time_job_scheduler_core;

  localparam int MAX_JOBS    = 1024;
  localparam int DRAIN_WAIT  = 200000;
  localparam int STALL_LIMIT = 400000;

  typedef struct packed {
    logic [motjs_pkg::DUR_W-1:0] dur;
    logic [motjs_pkg::DL_W-1:0]  dl;
  } job_t;

  typedef struct packed {
    logic [motjs_pkg::CNT_W-1:0] count;
    logic                        ovf;
  } sched_res_t;

  logic clk;
  logic rst;

  motjs_job_if jobs_if ();
  motjs_res_if res_if ();

  max_on_time_job_scheduler_core i_dut (
    .clk     (clk),
    .rst     (rst),
    .jobs    (jobs_if.sink),
    .results (res_if.source)
  );

  // Predictor state: jobs of the open batch, drop flag, expected results.
  job_t       batch_jobs[$];
  logic       batch_dropped;
  sched_res_t expected_counts[$];

  int mismatches;
  int send_idle_pct;
  int recv_idle_pct;
  int hold_off_cycles;
  int quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Moore-Hodgson on the stored batch: stable sort by deadline, then a
  // list of chosen durations, searched for its largest, with a running busy time.
  function automatic sched_res_t schedule_batch(job_t q[$], logic dropped);
    job_t                        sorted[$];
    logic [motjs_pkg::DUR_W-1:0] heap[$];
    longint unsigned             busy;
    int                          pos;
    int                          top;
    sched_res_t                  r;
    sorted = q;
    for (int i = 1; i < sorted.size(); i++) begin
      job_t key;
      key = sorted[i];
      pos = i - 1;
      while (pos >= 0 && sorted[pos].dl > key.dl) begin
        sorted[pos + 1] = sorted[pos];
        pos--;
      end
      sorted[pos + 1] = key;
    end
    busy = 0;
    foreach (sorted[i]) begin
      if (busy + sorted[i].dur <= sorted[i].dl) begin
        busy += sorted[i].dur;
        heap.push_back(sorted[i].dur);
      end else if (heap.size() > 0) begin
        top = 0;
        foreach (heap[k]) if (heap[k] > heap[top]) top = k;
        if (heap[top] > sorted[i].dur) begin
          busy = busy - heap[top] + sorted[i].dur;
          heap[top] = sorted[i].dur;
        end
      end
    end
    r.count = motjs_pkg::CNT_W'(heap.size());
    r.ovf   = dropped;
    return r;
  endfunction

  // Sends one request; the predictor runs on acceptance. Valid stays up
  // after acceptance and drops only when the sender idles.
  task automatic send_job(logic [motjs_pkg::DUR_W-1:0] dur,
                          logic [motjs_pkg::DL_W-1:0] dl, logic last);
    job_t j;
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      jobs_if.valid <= 1'b0;
      @(posedge clk);
    end
    jobs_if.valid        <= 1'b1;
    jobs_if.job_duration <= dur;
    jobs_if.job_deadline <= dl;
    jobs_if.last_job     <= last;
    @(posedge clk);
    while (!jobs_if.ready) @(posedge clk);
    j.dur = dur;
    j.dl  = dl;
    if (batch_jobs.size() < MAX_JOBS) batch_jobs.push_back(j);
    else batch_dropped = 1'b1;
    if (last) begin
      expected_counts.push_back(schedule_batch(batch_jobs, batch_dropped));
      batch_jobs.delete();
      batch_dropped = 1'b0;
    end
  endtask

  // Random batch; tight deadlines against durations keep the swap path busy.
  task automatic send_batch(int n, int span);
    for (int i = 0; i < n; i++)
      send_job(motjs_pkg::DUR_W'($urandom_range(span)),
               motjs_pkg::DL_W'($urandom_range(4 * span)), i == n - 1);
  endtask

  task automatic wait_drained();
    jobs_if.valid <= 1'b0;
    @(posedge clk);
    while (expected_counts.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    send_job('0, '0, 1'b1);                      // zero job fits at time zero
    send_job('1, '1, 1'b1);                      // max duration, max deadline
    send_job('1, '0, 1'b1);                      // never fits
    send_job(20'd5, 20'd4, 1'b0);                // two jobs too long for their deadlines, one that fits
    send_job(20'd3, 20'd7, 1'b0);
    send_job(20'd10, 20'd5, 1'b1);
    send_job(20'd4, 20'd10, 1'b0);               // equal deadlines keep order
    send_job(20'd4, 20'd10, 1'b0);
    send_job(20'd4, 20'd10, 1'b0);
    send_job(20'd1, 20'd2, 1'b1);
    send_job(20'h55555, 20'hAAAAA, 1'b0);        // alternating bit patterns
    send_job(20'hAAAAA, 20'h55555, 1'b1);
    send_job(20'd600000, 20'd600000, 1'b0);      // sums above the deadline range
    send_job(20'd600000, 20'hFFFFF, 1'b1);
  endtask

  // Store full: MAX_JOBS + extra requests, last one is dropped but closes the batch.
  task automatic test_overflow();
    for (int i = 0; i < MAX_JOBS + 3; i++)
      send_job(motjs_pkg::DUR_W'($urandom_range(50)),
               motjs_pkg::DL_W'($urandom_range(20000)), i == MAX_JOBS + 2);
    send_batch(2, 10);                           // flag must be clear again
  endtask

  task automatic test_random(int n_items);
    int sent;
    int n;
    sent = 0;
    while (sent < n_items) begin
      n = ($urandom_range(9) == 0) ? $urandom_range(60, 200) : $urandom_range(1, 12);
      if (n > n_items - sent) n = n_items - sent;
      case ($urandom_range(2))
        0: send_batch(n, 15);
        1: send_batch(n, 1000);
        default: send_batch(n, (1 << 18) - 1);
      endcase
      sent += n;
    end
  endtask

  // Receiver holds off while the sender keeps offering requests.
  task automatic test_back_pressure();
    hold_off_cycles = 3000;
    send_batch(3, 20);
    send_batch(4, 20);
    send_batch(5, 20);
    wait_drained();                              // sender pauses until all results are in
    send_batch(6, 200);
  endtask

  // Receiver: random stall, or a long hold-off when asked.
  always @(posedge clk) begin
    if (rst) begin
      res_if.ready <= 1'b0;
    end else if (hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      res_if.ready    <= 1'b0;
    end else begin
      res_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Result checker.
  always @(posedge clk) begin
    sched_res_t want;
    if (!rst && res_if.valid && res_if.ready) begin
      if (expected_counts.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: count=%0d overflow=%0b",
                   res_if.accepted_count, res_if.overflow);
      end else begin
        want = expected_counts.pop_front();
        if (res_if.accepted_count !== want.count || res_if.overflow !== want.ovf) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: count exp %0d got %0d, overflow exp %0b got %0b",
                     want.count, res_if.accepted_count, want.ovf, res_if.overflow);
        end
      end
    end
  end

  // Watchdog on cycles with no request or result accepted.
  always @(posedge clk) begin
    if (rst || (jobs_if.valid && jobs_if.ready) || (res_if.valid && res_if.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    mismatches           = 0;
    quiet_cycles         = 0;
    hold_off_cycles      = 0;
    send_idle_pct        = 10;
    recv_idle_pct        = 61;
    batch_dropped        = 1'b0;
    rst                  = 1'b1;
    jobs_if.valid        = 1'b0;
    jobs_if.job_duration = '0;
    jobs_if.job_deadline = '0;
    jobs_if.last_job     = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_random(20);
    send_idle_pct = 61;
    recv_idle_pct = 10;
    test_back_pressure();
    test_random(20);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_overflow();
    test_random(20);

    wait_drained();
    repeat (DRAIN_WAIT / 100) @(posedge clk);
    if (mismatches == 0 && expected_counts.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
